### design/fblm_pkg.sv
// Package for the fluid balance limit monitor.
// Holds the item, result, configuration and state types and the code constants.
// No dependencies.
package fblm_pkg;

	localparam int FRACTION_BITS_DEFAULT = 6;
	localparam int CFG_INDEX_W = 2;
	localparam int ACC_W = 32;
	localparam int WIDE_W = 34;
	localparam int MARGIN_ML = 5;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	localparam logic OP_PHASE = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [2:0] PHASE_CONNECTED = 3'd0;
	localparam logic [2:0] PHASE_PRIME = 3'd1;
	localparam logic [2:0] PHASE_RUN = 3'd2;
	localparam logic [2:0] PHASE_RINSEBACK = 3'd3;
	localparam logic [2:0] PHASE_DISCONNECT = 3'd4;
	localparam logic [2:0] PHASE_POST_RUN = 3'd5;
	localparam logic [2:0] PHASE_STORAGE = 3'd6;

	localparam logic [2:0] MODE_INACTIVE = 3'd0;
	localparam logic [2:0] MODE_FIRST_DRAW = 3'd1;
	localparam logic [2:0] MODE_RINSEBACK = 3'd3;
	localparam logic [2:0] MODE_DISCONNECT = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_LIMIT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERLOAD_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VALVE_THRESHOLD = 2'd2;

	localparam logic signed [20:0] OVERLOAD_RESET = -21'sd1048576;

	typedef struct packed {
		logic               operation;
		logic [2:0]         phase_code;
		logic [2:0]         mode_code;
		logic               donor_attached;
		logic               kit_known;
		logic               valve_returning;
		logic signed [15:0] inlet_delta;
		logic signed [15:0] return_delta;
		logic signed [15:0] anticoag_delta;
		logic signed [15:0] platelet_delta;
		logic signed [15:0] plasma_delta;
		logic signed [15:0] redcell_delta;
	} item_t;

	typedef struct packed {
		logic               low_volume_alarm;
		logic               high_volume_alarm;
		logic               valve_alarm;
		logic               fault_alarm;
		logic               rinseback_request;
		logic signed [31:0] volume_total;
	} result_t;

	typedef struct packed {
		logic [19:0]        volume_limit;
		logic signed [20:0] overload_limit;
		logic [7:0]         valve_fault_threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] volume_accumulator;
		logic                    low_monitor_on;
		logic                    high_monitor_on;
		logic                    request_sent;
		logic [7:0]              bad_valve_count;
	} state_t;

endpackage

### design/fblm_regs.sv
// Configuration registers of the fluid balance limit monitor.
// Depends on fblm_pkg for the register indexes and the cfg_t type.
module fblm_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [fblm_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [31:0]                          wr_data,
	output fblm_pkg::cfg_t                       cfg
);

	fblm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume_limit <= '0;
			cfg_q.overload_limit <= fblm_pkg::OVERLOAD_RESET;
			cfg_q.valve_fault_threshold <= '0;
		end else if (wr_en) begin
			case (wr_index)
				fblm_pkg::REG_VOLUME_LIMIT: cfg_q.volume_limit <= wr_data[19:0];
				fblm_pkg::REG_OVERLOAD_LIMIT: cfg_q.overload_limit <= wr_data[20:0];
				fblm_pkg::REG_VALVE_THRESHOLD: cfg_q.valve_fault_threshold <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/fblm_calc.sv
// Next-state and result logic of the fluid balance limit monitor.
// Depends on fblm_pkg for types and codes; purely combinational.
module fblm_calc #(
	parameter int FRACTION_BITS = fblm_pkg::FRACTION_BITS_DEFAULT
) (
	input  fblm_pkg::item_t   item,
	input  fblm_pkg::state_t  state,
	input  fblm_pkg::cfg_t    cfg,
	output fblm_pkg::state_t  state_next,
	output fblm_pkg::result_t result
);

	localparam int W = fblm_pkg::WIDE_W;
	localparam logic signed [W-1:0] MARGIN =
		W'(fblm_pkg::MARGIN_ML * (1 << FRACTION_BITS));
	localparam logic signed [W-1:0] ACC_MAX = W'(64'sd2147483647);
	localparam logic signed [W-1:0] ACC_MIN = -W'(64'sd2147483648);

	logic               active;
	logic signed [W-1:0] delta;
	logic signed [W-1:0] sum;
	logic signed [W-1:0] acc_sat;
	logic signed [W-1:0] limit_w;
	logic signed [W-1:0] over_w;
	logic [7:0]          count_inc;

	always_comb begin
		active = (item.mode_code >= fblm_pkg::MODE_FIRST_DRAW)
			&& (item.mode_code <= fblm_pkg::MODE_DISCONNECT) && item.donor_attached;
		if (active) begin
			delta = W'(item.inlet_delta) - W'(item.anticoag_delta) - W'(item.return_delta);
		end else begin
			delta = -(W'(item.anticoag_delta) + W'(item.platelet_delta)
				+ W'(item.plasma_delta) + W'(item.redcell_delta));
		end
		sum = W'(state.volume_accumulator) + delta;
		if (sum > ACC_MAX) begin
			acc_sat = ACC_MAX;
		end else if (sum < ACC_MIN) begin
			acc_sat = ACC_MIN;
		end else begin
			acc_sat = sum;
		end
		limit_w = W'({1'b0, cfg.volume_limit});
		over_w = W'(cfg.overload_limit);
		count_inc = (state.bad_valve_count == fblm_pkg::COUNT_MAX) ?
			state.bad_valve_count : state.bad_valve_count + 8'd1;

		state_next = state;
		result = '0;

		if (item.operation == fblm_pkg::OP_PHASE) begin
			case (item.phase_code)
				fblm_pkg::PHASE_CONNECTED, fblm_pkg::PHASE_PRIME, fblm_pkg::PHASE_RUN: begin
					state_next.low_monitor_on = 1'b1;
					state_next.high_monitor_on = 1'b1;
				end
				fblm_pkg::PHASE_RINSEBACK: begin
					state_next.low_monitor_on = 1'b1;
					state_next.high_monitor_on = 1'b1;
					state_next.bad_valve_count = '0;
				end
				fblm_pkg::PHASE_DISCONNECT: begin
					state_next.low_monitor_on = 1'b1;
					state_next.high_monitor_on = 1'b0;
				end
				fblm_pkg::PHASE_POST_RUN, fblm_pkg::PHASE_STORAGE: begin
					state_next.low_monitor_on = 1'b0;
					state_next.high_monitor_on = 1'b0;
				end
				default: ;
			endcase
		end else if ((state.low_monitor_on || state.high_monitor_on)
				&& item.mode_code != fblm_pkg::MODE_INACTIVE) begin
			result.fault_alarm = state.low_monitor_on && !item.kit_known;
			state_next.volume_accumulator = acc_sat[fblm_pkg::ACC_W-1:0];
			if (state.low_monitor_on) begin
				if ((limit_w - acc_sat < MARGIN) && !state.request_sent) begin
					state_next.request_sent = 1'b1;
					result.rinseback_request = 1'b1;
				end
				result.low_volume_alarm = acc_sat >= limit_w;
			end
			result.high_volume_alarm = state.high_monitor_on && (acc_sat <= over_w);
			if (item.mode_code == fblm_pkg::MODE_RINSEBACK && state.low_monitor_on
					&& !item.valve_returning) begin
				state_next.bad_valve_count = count_inc;
				result.valve_alarm = count_inc > cfg.valve_fault_threshold;
			end
		end
		result.volume_total = state_next.volume_accumulator;
	end

endmodule

### design/fluid_balance_limit_monitor.sv
// Fluid balance limit monitor: top level with input and result registers.
// An accepted item is held in the input register, and its result is then registered in the result register.
// Throughput: one item per cycle while result_stall is low, set by the single add, saturate and compare pass.
// Reset clears the accumulator, monitor enables, request flag and valve count,
// and loads the configuration registers with their reset values; no clearing pass.
// Depends on fblm_pkg, fblm_regs and fblm_calc.
module fluid_balance_limit_monitor #(
	parameter int FRACTION_BITS = fblm_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  fblm_pkg::item_t                  sample,
	output logic                             result_valid,
	input  logic                             result_stall,
	output fblm_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fblm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);

	fblm_pkg::cfg_t    cfg;
	fblm_pkg::state_t  state_q;
	fblm_pkg::state_t  state_next;
	fblm_pkg::result_t res_next;
	fblm_pkg::item_t   item_s1;
	fblm_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	assign cfg_ready = 1'b1;

	fblm_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	fblm_calc #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_calc (
		.item       (item_s1),
		.state      (state_q),
		.cfg        (cfg),
		.state_next (state_next),
		.result     (res_next)
	);

	assign advance = !valid_s2 || !result_stall;
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			item_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= res_next;
		end
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

endmodule

### tb/tb_top.sv
// Testbench for the fluid balance limit monitor: directed cases, full-scale swings of the total,
// a long result hold-off and three random idling mixes, each result checked field by field.
// Depends on fblm_pkg and the fluid_balance_limit_monitor RTL.
module tb_top;
	import fblm_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int RUN_LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_SAMPLES = 250;
	localparam int SWING_ITEMS = 60;
	localparam logic [2:0] PHASE_OTHER = 3'd7;
	localparam logic [2:0] MODE_DRAW_DONE = 3'd2;
	localparam logic [2:0] MODE_OTHER = 3'd5;
	localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
	localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam longint ACC_MAX = 64'sd2147483647;
	localparam longint ACC_MIN = -64'sd2147483648;
	localparam longint REMOVAL_MARGIN = longint'(MARGIN_ML) << FRACTION_BITS_DEFAULT;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	item_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// model copy of the registers and state
	logic [19:0] vol_limit_cfg = '0;
	logic signed [20:0] overload_cfg = OVERLOAD_RESET;
	logic [7:0] valve_thr_cfg = '0;
	logic signed [ACC_W-1:0] balance_acc = '0;
	logic low_watch = 1'b0;
	logic high_watch = 1'b0;
	logic rinse_req_sent = 1'b0;
	logic [7:0] bad_valve_cnt = '0;
	bit sample_counted;

	result_t pending_results[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asks = 0;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;

	fluid_balance_limit_monitor dut (.*);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic result_t predict_balance(item_t it);
		result_t r;
		longint total;
		r = '0;
		sample_counted = 1'b0;
		if (it.operation == OP_PHASE) begin
			case (it.phase_code)
				PHASE_CONNECTED, PHASE_PRIME, PHASE_RUN: begin
					low_watch = 1'b1;
					high_watch = 1'b1;
				end
				PHASE_RINSEBACK: begin
					low_watch = 1'b1;
					high_watch = 1'b1;
					bad_valve_cnt = '0;
				end
				PHASE_DISCONNECT: begin
					low_watch = 1'b1;
					high_watch = 1'b0;
				end
				PHASE_POST_RUN, PHASE_STORAGE: begin
					low_watch = 1'b0;
					high_watch = 1'b0;
				end
				default: ;
			endcase
		end else if ((low_watch || high_watch) && it.mode_code != MODE_INACTIVE) begin
			sample_counted = 1'b1;
			r.fault_alarm = low_watch && !it.kit_known;
			total = longint'(balance_acc);
			if (it.mode_code >= MODE_FIRST_DRAW && it.mode_code <= MODE_DISCONNECT
					&& it.donor_attached)
				total += longint'($signed(it.inlet_delta)) - longint'($signed(it.anticoag_delta))
					- longint'($signed(it.return_delta));
			else
				total -= longint'($signed(it.anticoag_delta)) + longint'($signed(it.platelet_delta))
					+ longint'($signed(it.plasma_delta)) + longint'($signed(it.redcell_delta));
			if (total > ACC_MAX)
				total = ACC_MAX;
			if (total < ACC_MIN)
				total = ACC_MIN;
			balance_acc = total[ACC_W-1:0];
			if (low_watch) begin
				if (longint'(vol_limit_cfg) - total < REMOVAL_MARGIN && !rinse_req_sent) begin
					rinse_req_sent = 1'b1;
					r.rinseback_request = 1'b1;
				end
				r.low_volume_alarm = total >= longint'(vol_limit_cfg);
			end
			r.high_volume_alarm = high_watch && total <= longint'(overload_cfg);
			if (it.mode_code == MODE_RINSEBACK && low_watch && !it.valve_returning) begin
				if (bad_valve_cnt != COUNT_MAX)
					bad_valve_cnt++;
				r.valve_alarm = bad_valve_cnt > valve_thr_cfg;
			end
		end
		r.volume_total = balance_acc;
		return r;
	endfunction

	function automatic logic signed [15:0] random_volume();
		logic signed [15:0] v;
		if ($urandom_range(0, 99) < 5)
			v = 16'($urandom());
		else begin
			v = 16'($urandom_range(0, 1500));
			if ($urandom_range(0, 1))
				v = -v;
		end
		return v;
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.operation = ($urandom_range(0, 99) < 10) ? OP_PHASE : OP_SAMPLE;
		it.phase_code = 3'($urandom_range(PHASE_CONNECTED, PHASE_OTHER));
		it.mode_code = ($urandom_range(0, 99) < 80)
			? 3'($urandom_range(MODE_FIRST_DRAW, MODE_DISCONNECT))
			: 3'($urandom_range(MODE_INACTIVE, MODE_UNDEF_HI));
		it.donor_attached = 1'($urandom_range(0, 1));
		it.kit_known = ($urandom_range(0, 99) < 90);
		it.valve_returning = 1'($urandom_range(0, 1));
		it.inlet_delta = random_volume();
		it.return_delta = random_volume();
		it.anticoag_delta = random_volume();
		it.platelet_delta = random_volume();
		it.plasma_delta = random_volume();
		it.redcell_delta = random_volume();
		return it;
	endfunction

	function automatic item_t phase_item(logic [2:0] phase);
		item_t it;
		it = random_item();
		it.operation = OP_PHASE;
		it.phase_code = phase;
		return it;
	endfunction

	function automatic item_t sample_item(logic [2:0] mode, logic donor, logic kit, logic valve,
			logic signed [15:0] inlet, ret, anticoag, platelet, plasma, redcell);
		item_t it;
		it = random_item();
		it.operation = OP_SAMPLE;
		it.mode_code = mode;
		it.donor_attached = donor;
		it.kit_known = kit;
		it.valve_returning = valve;
		it.inlet_delta = inlet;
		it.return_delta = ret;
		it.anticoag_delta = anticoag;
		it.platelet_delta = platelet;
		it.plasma_delta = plasma;
		it.redcell_delta = redcell;
		return it;
	endfunction

	task automatic send_item(item_t it);
		bit stalled;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample <= it;
		sample_valid <= 1'b1;
		do begin
			@(negedge clk);
			stalled = sample_stall;
			@(posedge clk);
		end while (stalled);
		pending_results.push_back(predict_balance(it));
		items_sent++;
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
		logic [31:0] data;
		bit ready_seen;
		data = $urandom();
		case (idx)
			REG_VOLUME_LIMIT: data[19:0] = value[19:0];
			REG_OVERLOAD_LIMIT: data[20:0] = value[20:0];
			REG_VALVE_THRESHOLD: data[7:0] = value[7:0];
			default: ;
		endcase
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			ready_seen = cfg_ready;
			@(posedge clk);
		end while (!ready_seen);
		cfg_valid <= 1'b0;
		case (idx)
			REG_VOLUME_LIMIT: vol_limit_cfg = data[19:0];
			REG_OVERLOAD_LIMIT: overload_cfg = data[20:0];
			REG_VALVE_THRESHOLD: valve_thr_cfg = data[7:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	function automatic void check_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	initial begin : result_checker
		result_t want;
		forever begin
			@(negedge clk);
			if (result_valid && !result_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result with no item pending: volume_total %0d",
						$signed(result.volume_total));
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("low_volume_alarm", 64'(want.low_volume_alarm),
						64'(result.low_volume_alarm));
					check_field("high_volume_alarm", 64'(want.high_volume_alarm),
						64'(result.high_volume_alarm));
					check_field("valve_alarm", 64'(want.valve_alarm), 64'(result.valve_alarm));
					check_field("fault_alarm", 64'(want.fault_alarm), 64'(result.fault_alarm));
					check_field("rinseback_request", 64'(want.rinseback_request),
						64'(result.rinseback_request));
					check_field("volume_total", 64'(want.volume_total),
						64'(result.volume_total));
				end
			end
		end
	end

	initial begin : result_hold
		int hold_left;
		int asks_served;
		hold_left = 0;
		asks_served = 0;
		forever begin
			@(posedge clk);
			if (asks_served != hold_asks) begin
				asks_served = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else
				result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin : run_limit
		repeat (RUN_LIMIT_CYCLES) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic test_idle_after_reset();
		send_item(sample_item(MODE_FIRST_DRAW, 1'b1, 1'b1, 1'b1, 16'sd100, '0, '0, '0, '0, '0));
		send_item(phase_item(PHASE_OTHER));
		send_item(sample_item(MODE_OTHER, 1'b0, 1'b0, 1'b0, '0, '0, 16'sd50, '0, '0, '0));
	endtask

	task automatic test_register_setup();
		drain_results();
		write_reg(REG_VOLUME_LIMIT, 32'd1000);
		write_reg(REG_OVERLOAD_LIMIT, -32'sd2000);
		write_reg(REG_VALVE_THRESHOLD, 32'd1);
		write_reg(REG_SPARE, '0);
	endtask

	task automatic test_phase_table();
		logic [2:0] phase_order [8] = '{PHASE_CONNECTED, PHASE_PRIME, PHASE_RUN, PHASE_OTHER,
			PHASE_RINSEBACK, PHASE_DISCONNECT, PHASE_POST_RUN, PHASE_STORAGE};
		foreach (phase_order[i]) begin
			send_item(phase_item(phase_order[i]));
			send_item(sample_item(MODE_FIRST_DRAW, 1'b1, 1'b0, 1'b1, '0, '0, '0, '0, '0, '0));
		end
	endtask

	task automatic test_rinseback_request();
		send_item(phase_item(PHASE_RUN));
		send_item(sample_item(MODE_FIRST_DRAW, 1'b1, 1'b1, 1'b1, 16'sd700, '0, '0, '0, '0, '0));
		send_item(sample_item(MODE_DRAW_DONE, 1'b1, 1'b1, 1'b1, 16'sd400, '0, '0, '0, '0, '0));
		send_item(sample_item(MODE_UNDEF_LO, 1'b1, 1'b1, 1'b1, 16'sd9, '0, 16'sd300, '0, '0, '0));
		send_item(sample_item(MODE_UNDEF_HI, 1'b1, 1'b1, 1'b1, 16'sd9, '0, '0, 16'sd300, '0, '0));
		send_item(sample_item(MODE_DISCONNECT, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh8000,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		send_item(sample_item(MODE_OTHER, 1'b0, 1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		send_item(sample_item(MODE_DRAW_DONE, 1'b1, 1'b1, 1'b1, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
			16'sh8000, 16'sh8000, 16'sh8000));
		send_item(sample_item(MODE_OTHER, 1'b1, 1'b1, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000));
	endtask

	task automatic test_valve_count();
		drain_results();
		write_reg(REG_VALVE_THRESHOLD, 32'd1);
		send_item(phase_item(PHASE_RINSEBACK));
		repeat (3)
			send_item(sample_item(MODE_RINSEBACK, 1'b0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0));
		send_item(phase_item(PHASE_RINSEBACK));
		send_item(sample_item(MODE_RINSEBACK, 1'b0, 1'b1, 1'b1, '0, '0, '0, '0, '0, '0));
		send_item(sample_item(MODE_RINSEBACK, 1'b0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0));
	endtask

	// swing the total up, well below zero, then back with full-scale deltas
	task automatic test_large_swings();
		drain_results();
		write_reg(REG_VALVE_THRESHOLD, 32'd255);
		send_item(phase_item(PHASE_RUN));
		repeat (SWING_ITEMS)
			send_item(sample_item(MODE_RINSEBACK, 1'b0, 1'b1, 1'b0, random_volume(),
				random_volume(), 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
		repeat (2 * SWING_ITEMS)
			send_item(sample_item(MODE_RINSEBACK, 1'b0, 1'b1, 1'b0, random_volume(),
				random_volume(), 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		repeat (SWING_ITEMS)
			send_item(sample_item(MODE_RINSEBACK, 1'b0, 1'b1, 1'b0, random_volume(),
				random_volume(), 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
	endtask

	task automatic test_result_hold();
		drain_results();
		hold_asks++;
		repeat (40) send_item(random_item());
		drain_results();
	endtask

	task automatic test_random_traffic();
		int idle_send [3] = '{11, 50, 0};
		int idle_recv [3] = '{50, 11, 0};
		int counted;
		for (int p = 0; p < 3; p++) begin
			drain_results();
			case (p)
				0: begin
					write_reg(REG_VOLUME_LIMIT, 32'hFFFFF);
					write_reg(REG_OVERLOAD_LIMIT, 32'(OVERLOAD_RESET));
					write_reg(REG_VALVE_THRESHOLD, 32'hFF);
				end
				1: begin
					write_reg(REG_VOLUME_LIMIT, '0);
					write_reg(REG_OVERLOAD_LIMIT, '0);
					write_reg(REG_VALVE_THRESHOLD, '0);
				end
				default: begin
					write_reg(REG_VOLUME_LIMIT, $urandom_range(0, 200000));
					write_reg(REG_OVERLOAD_LIMIT, -$urandom_range(0, 200000));
					write_reg(REG_VALVE_THRESHOLD, $urandom_range(0, 8));
				end
			endcase
			send_idle_pct = idle_send[p];
			recv_stall_pct = idle_recv[p];
			counted = 0;
			while (counted < RANDOM_SAMPLES) begin
				send_item(random_item());
				if (sample_counted)
					counted++;
			end
		end
		drain_results();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_after_reset();
		test_register_setup();
		test_phase_table();
		test_rinseback_request();
		test_valve_count();
		test_large_swings();
		test_result_hold();
		test_random_traffic();
		$display("Sent %0d items, checked %0d results, made %0d register writes;",
			items_sent, results_seen, reg_writes);
		$display("covered the phase table, full-scale swings, a long hold-off and three idling mixes.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
